// ===== rtl/rpv_pkg.sv =====
// rpv_pkg: shared constants, types and helpers for the row projection variance unit
// holds field widths, configuration register codes, the row record and the divider request
// no dependencies
package rpv_pkg;

  // frame limits and fixed-point scale
  localparam int MAX_WIDTH  = 4096;
  localparam int MAX_HEIGHT = 4096;
  localparam int FRAC_BITS  = 8;

  // field widths
  localparam int PIX_W  = 8;
  localparam int CFG_W  = 13;
  localparam int CNT_W  = 13;
  localparam int POS_W  = 12;
  localparam int MEAN_W = 21;
  localparam int VAR_W  = 31;

  // accumulator and arithmetic widths
  localparam int SUM_W     = 25;
  localparam int SQ_W      = 37;
  localparam int PROD_W    = CFG_W + SQ_W;
  localparam int DIV_W     = PROD_W + FRAC_BITS;
  localparam int DVSR_W    = 2 * CFG_W - 1;
  localparam int DIV_CNT_W = $clog2(DIV_W);

  // stream widths
  localparam int IN_TDATA_W  = 3 * PIX_W;
  localparam int OUT_FIELD_W = CNT_W + POS_W + MEAN_W + VAR_W;
  localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

  // row queue
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);

  // configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_COLUMNS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS    = 1'b1;

  // register reset values
  localparam logic [CFG_W-1:0] COLUMNS_RST = CFG_W'(640);
  localparam logic [CFG_W-1:0] ROWS_RST    = CFG_W'(480);

  // one finished row handed from front to back
  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic [POS_W-1:0] row;
    logic             last;
    logic [CFG_W-1:0] nrows;
  } row_rec_t;

  // request to the shared divider
  typedef struct packed {
    logic              start;
    logic [DIV_W-1:0]  dividend;
    logic [DVSR_W-1:0] divisor;
  } div_req_t;

  // clamp a register value to 1..hi
  function automatic logic [CFG_W-1:0] clamp_cfg(input logic [CFG_W-1:0] v,
                                                 input logic [CFG_W-1:0] hi);
    logic [CFG_W-1:0] res;
    if (v == '0) begin
      res = CFG_W'(1);
    end else if (v > hi) begin
      res = hi;
    end else begin
      res = v;
    end
    return res;
  endfunction

endpackage

// ===== rtl/row_projection_variance_unit.sv =====
// row_projection_variance_unit: throughput one pixel per cycle while the back end keeps up;
// the back end handles each row in its own sequence and, on the last row of a frame, also
// waits twice on the shared bit-serial divider; this is absorbed by a 4-entry row queue.
// a row result passes from the row queue through the back end sequencer to the output register.
// synchronous active-low reset clears positions, accumulators and queue, restores
// columns to 640 and rows to 480.
module row_projection_variance_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  // in_tdata: red [7:0], green [15:8], blue [23:16]
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [rpv_pkg::IN_TDATA_W-1:0]      in_tdata,
  // out_tdata: row_black_count, row_index, mean_fixed, variance_fixed, zero padding
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [rpv_pkg::OUT_TDATA_W-1:0]     out_tdata,
  // out_tuser: frame_done
  output logic                                out_tuser,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [rpv_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [rpv_pkg::CFG_W-1:0]           cfg_data
);
  import rpv_pkg::*;

  row_rec_t          push_rec;
  row_rec_t          pop_rec;
  logic              push;
  logic              pop;
  logic              q_full;
  logic              q_empty;
  div_req_t          div_req;
  logic              div_done;
  logic [DIV_W-1:0]  div_q;
  logic [CNT_W-1:0]  out_count;
  logic [POS_W-1:0]  out_row;
  logic [MEAN_W-1:0] out_mean;
  logic [VAR_W-1:0]  out_var;

  assign cfg_ready = 1'b1;

  // pixel front end
  rpv_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pix_valid (in_tvalid),
    .pix_ready (in_tready),
    .red       (in_tdata[PIX_W-1:0]),
    .green     (in_tdata[2*PIX_W-1:PIX_W]),
    .blue      (in_tdata[3*PIX_W-1:2*PIX_W]),
    .q_full    (q_full),
    .push      (push),
    .rec       (push_rec)
  );

  // row queue
  rpv_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .wr_rec (push_rec),
    .pop    (pop),
    .rd_rec (pop_rec),
    .full   (q_full),
    .empty  (q_empty)
  );

  // back end
  rpv_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_rec     (pop_rec),
    .pop       (pop),
    .div_req   (div_req),
    .div_done  (div_done),
    .div_q     (div_q),
    .out_ready (out_tready),
    .out_valid (out_tvalid),
    .out_count (out_count),
    .out_row   (out_row),
    .out_last  (out_tuser),
    .out_mean  (out_mean),
    .out_var   (out_var)
  );

  // shared divider
  rpv_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (div_req),
    .done     (div_done),
    .quotient (div_q)
  );

  // result packing, first field lowest
  assign out_tdata = {(OUT_TDATA_W-OUT_FIELD_W)'(0), out_var, out_mean, out_row, out_count};

endmodule

// ===== rtl/rpv_front.sv =====
// rpv_front: pixel front end, configuration registers and per-row black pixel counting
// pushes one row record per finished row into the row queue
// depends on rpv_pkg
module rpv_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  input  logic [rpv_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rpv_pkg::CFG_W-1:0]      cfg_data,
  input  logic                           pix_valid,
  output logic                           pix_ready,
  input  logic [rpv_pkg::PIX_W-1:0]      red,
  input  logic [rpv_pkg::PIX_W-1:0]      green,
  input  logic [rpv_pkg::PIX_W-1:0]      blue,
  input  logic                           q_full,
  output logic                           push,
  output rpv_pkg::row_rec_t              rec
);
  import rpv_pkg::*;

  logic [CFG_W-1:0] columns_r, columns_nxt;
  logic [CFG_W-1:0] rows_r, rows_nxt;
  logic [POS_W-1:0] col_pos_r, col_pos_nxt;
  logic [POS_W-1:0] row_pos_r, row_pos_nxt;
  logic [CNT_W-1:0] cur_cnt_r, cur_cnt_nxt;

  logic [CFG_W-1:0] cols_eff;
  logic [CFG_W-1:0] rows_eff;
  logic             accept;
  logic             black;
  logic [CNT_W-1:0] cnt_now;
  logic             row_end;
  logic             last_row;

  // a full queue holds the pixel stream back
  assign pix_ready = !q_full;
  assign accept    = pix_valid && !q_full;

  // effective frame geometry
  assign cols_eff = clamp_cfg(columns_r, CFG_W'(MAX_WIDTH));
  assign rows_eff = clamp_cfg(rows_r, CFG_W'(MAX_HEIGHT));

  // pixel classification and row / frame end detection
  assign black    = (red == '0) && (green == '0) && (blue == '0);
  assign cnt_now  = cur_cnt_r + CNT_W'(black);
  assign row_end  = (CFG_W'(col_pos_r) + CFG_W'(1)) >= cols_eff;
  assign last_row = (CFG_W'(row_pos_r) + CFG_W'(1)) >= rows_eff;

  // row record towards the back end
  assign push      = accept && row_end;
  assign rec.count = cnt_now;
  assign rec.row   = row_pos_r;
  assign rec.last  = last_row;
  assign rec.nrows = rows_eff;

  // configuration writes
  always_comb begin
    columns_nxt = columns_r;
    rows_nxt    = rows_r;
    if (cfg_valid) begin
      case (cfg_index)
        REG_COLUMNS: columns_nxt = cfg_data;
        REG_ROWS:    rows_nxt    = cfg_data;
        default: ;
      endcase
    end
  end

  // position and count update
  always_comb begin
    col_pos_nxt = col_pos_r;
    row_pos_nxt = row_pos_r;
    cur_cnt_nxt = cur_cnt_r;
    if (accept) begin
      if (row_end) begin
        col_pos_nxt = '0;
        cur_cnt_nxt = '0;
        row_pos_nxt = last_row ? '0 : row_pos_r + POS_W'(1);
      end else begin
        col_pos_nxt = col_pos_r + POS_W'(1);
        cur_cnt_nxt = cnt_now;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      columns_r <= COLUMNS_RST;
      rows_r    <= ROWS_RST;
      col_pos_r <= '0;
      row_pos_r <= '0;
      cur_cnt_r <= '0;
    end else begin
      columns_r <= columns_nxt;
      rows_r    <= rows_nxt;
      col_pos_r <= col_pos_nxt;
      row_pos_r <= row_pos_nxt;
      cur_cnt_r <= cur_cnt_nxt;
    end
  end

endmodule

// ===== rtl/rpv_queue.sv =====
// rpv_queue: short register queue of row records between front and back end
// depends on rpv_pkg
module rpv_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  rpv_pkg::row_rec_t wr_rec,
  input  logic              pop,
  output rpv_pkg::row_rec_t rd_rec,
  output logic              full,
  output logic              empty
);
  import rpv_pkg::*;

  row_rec_t           mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wptr_r, wptr_nxt;
  logic [Q_PTR_W-1:0] rptr_r, rptr_nxt;
  logic [Q_PTR_W:0]   fill_r, fill_nxt;
  logic               do_push;
  logic               do_pop;

  assign full    = fill_r == (Q_PTR_W+1)'(Q_DEPTH);
  assign empty   = fill_r == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_rec  = mem_r[rptr_r];

  // pointer and fill level update
  always_comb begin
    wptr_nxt = do_push ? wptr_r + Q_PTR_W'(1) : wptr_r;
    rptr_nxt = do_pop ? rptr_r + Q_PTR_W'(1) : rptr_r;
    fill_nxt = fill_r;
    if (do_push && !do_pop) begin
      fill_nxt = fill_r + (Q_PTR_W+1)'(1);
    end else if (do_pop && !do_push) begin
      fill_nxt = fill_r - (Q_PTR_W+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      fill_r <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      fill_r <= fill_nxt;
    end
  end

  // storage, no reset
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= wr_rec;
    end
  end

endmodule

// ===== rtl/rpv_div.sv =====
// rpv_div: restoring divider, one quotient bit per cycle, shared by mean and variance
// depends on rpv_pkg
module rpv_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  rpv_pkg::div_req_t          req,
  output logic                       done,
  output logic [rpv_pkg::DIV_W-1:0]  quotient
);
  import rpv_pkg::*;

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] step_r, step_nxt;
  logic [DIV_W-1:0]     work_r, work_nxt;
  logic [DVSR_W-1:0]    rem_r, rem_nxt;
  logic [DVSR_W-1:0]    dvsr_r, dvsr_nxt;

  logic [DVSR_W:0]      trial;
  logic                 take;
  logic [DVSR_W:0]      diff;

  // one restoring step
  assign trial = {rem_r, work_r[DIV_W-1]};
  assign take  = trial >= {1'b0, dvsr_r};
  assign diff  = trial - {1'b0, dvsr_r};

  assign done     = done_r;
  assign quotient = work_r;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    work_nxt = work_r;
    rem_nxt  = rem_r;
    dvsr_nxt = dvsr_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      work_nxt = req.dividend;
      rem_nxt  = '0;
      dvsr_nxt = req.divisor;
    end else if (busy_r) begin
      work_nxt = {work_r[DIV_W-2:0], take};
      rem_nxt  = take ? diff[DVSR_W-1:0] : trial[DVSR_W-1:0];
      step_nxt = step_r + DIV_CNT_W'(1);
      // final quotient bit
      if (step_r == DIV_CNT_W'(DIV_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    work_r <= work_nxt;
    rem_r  <= rem_nxt;
    dvsr_r <= dvsr_nxt;
  end

endmodule

// ===== rtl/rpv_back.sv =====
// rpv_back: back end sequencer, frame accumulators, frame statistics and output register
// drives the shared divider for mean and variance at the end of each frame
// depends on rpv_pkg
module rpv_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_empty,
  input  rpv_pkg::row_rec_t             q_rec,
  output logic                          pop,
  output rpv_pkg::div_req_t             div_req,
  input  logic                          div_done,
  input  logic [rpv_pkg::DIV_W-1:0]     div_q,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic [rpv_pkg::CNT_W-1:0]     out_count,
  output logic [rpv_pkg::POS_W-1:0]     out_row,
  output logic                          out_last,
  output logic [rpv_pkg::MEAN_W-1:0]    out_mean,
  output logic [rpv_pkg::VAR_W-1:0]     out_var
);
  import rpv_pkg::*;

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_ACC  = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_SUB  = 3'd3;
  localparam logic [2:0] S_DIVM = 3'd4;
  localparam logic [2:0] S_DIVV = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  logic [2:0]        state_r, state_nxt;
  row_rec_t          rec_r, rec_nxt;
  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic [SQ_W-1:0]   sqsum_r, sqsum_nxt;
  logic [PROD_W-1:0] a_r, a_nxt;
  logic [PROD_W-1:0] s2_r, s2_nxt;
  logic [DVSR_W-1:0] rr_r, rr_nxt;
  logic [PROD_W-1:0] diff_r, diff_nxt;
  logic [MEAN_W-1:0] mean_r, mean_nxt;
  logic [VAR_W-1:0]  var_r, var_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [CNT_W-1:0]  out_count_r;
  logic [POS_W-1:0]  out_row_r;
  logic              out_last_r;
  logic [MEAN_W-1:0] out_mean_r;
  logic [VAR_W-1:0]  out_var_r;
  logic              load_out;
  logic              out_free;

  logic [2*CNT_W-1:0] sq;
  logic [PROD_W-1:0]  a_prod;
  logic [PROD_W-1:0]  s2_prod;
  logic [2*CFG_W-1:0] rr_prod;

  // products: sq for the accumulate step, the other three for the multiply step
  assign sq      = rec_r.count * rec_r.count;
  assign a_prod  = PROD_W'(rec_r.nrows) * PROD_W'(sqsum_r);
  assign s2_prod = PROD_W'(sum_r) * PROD_W'(sum_r);
  assign rr_prod = rec_r.nrows * rec_r.nrows;

  assign out_free = !out_valid_r || out_ready;

  // sequencer
  always_comb begin
    state_nxt        = state_r;
    rec_nxt          = rec_r;
    sum_nxt          = sum_r;
    sqsum_nxt        = sqsum_r;
    a_nxt            = a_r;
    s2_nxt           = s2_r;
    rr_nxt           = rr_r;
    diff_nxt         = diff_r;
    mean_nxt         = mean_r;
    var_nxt          = var_r;
    pop              = 1'b0;
    load_out         = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = DIV_W'(sum_r) << FRAC_BITS;
    div_req.divisor  = DVSR_W'(rec_r.nrows);
    case (state_r)
      S_IDLE: begin
        if (!q_empty) begin
          pop       = 1'b1;
          rec_nxt   = q_rec;
          state_nxt = S_ACC;
        end
      end
      S_ACC: begin
        sum_nxt   = sum_r + SUM_W'(rec_r.count);
        sqsum_nxt = sqsum_r + SQ_W'(sq);
        state_nxt = rec_r.last ? S_MUL : S_OUT;
      end
      S_MUL: begin
        a_nxt     = a_prod;
        s2_nxt    = s2_prod;
        rr_nxt    = DVSR_W'(rr_prod);
        state_nxt = S_SUB;
      end
      S_SUB: begin
        // clamp at zero, then start the mean division
        diff_nxt      = (a_r >= s2_r) ? a_r - s2_r : '0;
        div_req.start = 1'b1;
        state_nxt     = S_DIVM;
      end
      S_DIVM: begin
        div_req.dividend = DIV_W'(diff_r) << FRAC_BITS;
        div_req.divisor  = rr_r;
        if (div_done) begin
          mean_nxt      = div_q[MEAN_W-1:0];
          div_req.start = 1'b1;
          state_nxt     = S_DIVV;
        end
      end
      S_DIVV: begin
        if (div_done) begin
          var_nxt   = div_q[VAR_W-1:0];
          sum_nxt   = '0;
          sqsum_nxt = '0;
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          load_out  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // output register valid flag
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      sum_r       <= '0;
      sqsum_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sum_r       <= sum_nxt;
      sqsum_r     <= sqsum_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // working and output payload
  always_ff @(posedge clk) begin
    rec_r  <= rec_nxt;
    a_r    <= a_nxt;
    s2_r   <= s2_nxt;
    rr_r   <= rr_nxt;
    diff_r <= diff_nxt;
    mean_r <= mean_nxt;
    var_r  <= var_nxt;
    if (load_out) begin
      out_count_r <= rec_r.count;
      out_row_r   <= rec_r.row;
      out_last_r  <= rec_r.last;
      out_mean_r  <= rec_r.last ? mean_r : '0;
      out_var_r   <= rec_r.last ? var_r : '0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_count = out_count_r;
  assign out_row   = out_row_r;
  assign out_last  = out_last_r;
  assign out_mean  = out_mean_r;
  assign out_var   = out_var_r;

endmodule

// ===== rtl/rpv_checker.sv =====
// rpv_checker: port-level checks on the result stream of the row projection variance unit
// attached to the top level by the bind below; depends on rpv_pkg
module rpv_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [rpv_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input logic                             out_tuser
);
  import rpv_pkg::*;

  localparam int MEAN_LO = CNT_W + POS_W;
  localparam int VAR_HI  = MEAN_LO + MEAN_W + VAR_W - 1;

  // a stalled result stays offered
  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result withdrawn while stalled");

  // a stalled result keeps its payload
  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser))
    else $error("result payload changed while stalled");

  // statistics only on the last row of a frame
  a_stats_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[VAR_HI:MEAN_LO] == '0)
    else $error("mean or variance set on a non-final row");

  // padding bits stay clear
  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[OUT_TDATA_W-1:OUT_FIELD_W] == '0)
    else $error("padding bits set");

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result offered after reset");

endmodule

bind row_projection_variance_unit rpv_checker u_rpv_checker (.*);

// ===== verif/testbench.sv =====
// testbench for row_projection_variance_unit: pixel stream in, row and frame statistics out
// predicts each row result from its own model of the counters and checks it field by field
// depends on rpv_pkg for widths and register indexes
`timescale 1ns / 1ps

module testbench;
  import rpv_pkg::*;

  localparam int CYCLE_LIMIT   = 1_500_000;
  localparam int SETTLE_CYCLES = 300;
  localparam int GAP_MAX       = 8;

  // bit positions of the result fields in out_tdata
  localparam int COUNT_LO = 0;
  localparam int ROW_LO   = COUNT_LO + CNT_W;
  localparam int MEAN_LO  = ROW_LO + POS_W;
  localparam int VAR_LO   = MEAN_LO + MEAN_W;

  typedef struct {
    bit [CNT_W-1:0]  black_count;
    bit [POS_W-1:0]  row_index;
    bit              frame_done;
    bit [MEAN_W-1:0] mean_fixed;
    bit [VAR_W-1:0]  variance_fixed;
  } row_stats_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tuser;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_W-1:0]       cfg_data;

  row_projection_variance_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // 20 ns clock
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // shared run state
  row_stats_t rows_due[$];
  int         mismatches   = 0;
  int         in_gap_max   = GAP_MAX;
  int         out_gap_max  = GAP_MAX;
  longint     cycle_count  = 0;

  // predictor copy of the registers and counters
  bit [CFG_W-1:0] geo_columns;
  bit [CFG_W-1:0] geo_rows;
  bit [POS_W-1:0] col_pos;
  bit [POS_W-1:0] row_pos;
  bit [CNT_W-1:0] row_black;
  bit [SUM_W-1:0] black_sum;
  bit [SQ_W-1:0]  black_sq_sum;

  // register value limited to 1..hi
  function automatic bit [CFG_W-1:0] fit_geometry(bit [CFG_W-1:0] v, int hi);
    bit [CFG_W-1:0] res;
    if (v == '0) begin
      res = CFG_W'(1);
    end else if (int'(v) > hi) begin
      res = CFG_W'(hi);
    end else begin
      res = v;
    end
    return res;
  endfunction

  // advance the counters by one pixel, queue the row statistics at a row end
  function automatic void predict_pixel(bit [PIX_W-1:0] r, bit [PIX_W-1:0] g,
                                        bit [PIX_W-1:0] b);
    bit [CFG_W-1:0] cols;
    bit [CFG_W-1:0] nrows;
    bit [CNT_W-1:0] cnt;
    bit [63:0]      weighted;
    bit [63:0]      sum_sq;
    bit [63:0]      diff;
    row_stats_t     res;
    cols  = fit_geometry(geo_columns, MAX_WIDTH);
    nrows = fit_geometry(geo_rows, MAX_HEIGHT);
    if (r == '0 && g == '0 && b == '0) begin
      row_black++;
    end
    if (int'(col_pos) + 1 < int'(cols)) begin
      col_pos++;
    end else begin
      // row end
      cnt          = row_black;
      col_pos      = '0;
      row_black    = '0;
      black_sum    = black_sum + SUM_W'(cnt);
      black_sq_sum = black_sq_sum + SQ_W'(cnt) * SQ_W'(cnt);
      res.black_count    = cnt;
      res.row_index      = row_pos;
      res.frame_done     = (int'(row_pos) + 1 >= int'(nrows));
      res.mean_fixed     = '0;
      res.variance_fixed = '0;
      if (res.frame_done) begin
        weighted = 64'(nrows) * 64'(black_sq_sum);
        sum_sq   = 64'(black_sum) * 64'(black_sum);
        diff     = (weighted >= sum_sq) ? weighted - sum_sq : 64'd0;
        res.mean_fixed     = MEAN_W'((64'(black_sum) << FRAC_BITS) / 64'(nrows));
        res.variance_fixed = VAR_W'((diff << FRAC_BITS) / (64'(nrows) * 64'(nrows)));
        black_sum    = '0;
        black_sq_sum = '0;
        row_pos      = '0;
      end else begin
        row_pos++;
      end
      rows_due.push_back(res);
    end
  endfunction

  function automatic void check_field(string name, longint unsigned want,
                                      longint unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // result side: random stalls, compare each item with the oldest prediction
  initial begin
    int         stall;
    row_stats_t want;
    out_tready = 1'b0;
    stall      = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        if (rows_due.size() == 0) begin
          $error("unexpected result: row_index %0d row_black_count %0d",
                 out_tdata[ROW_LO +: POS_W], out_tdata[COUNT_LO +: CNT_W]);
          mismatches++;
        end else begin
          want = rows_due.pop_front();
          check_field("row_black_count", want.black_count, out_tdata[COUNT_LO +: CNT_W]);
          check_field("row_index", want.row_index, out_tdata[ROW_LO +: POS_W]);
          check_field("frame_done", want.frame_done, out_tuser);
          check_field("mean_fixed", want.mean_fixed, out_tdata[MEAN_LO +: MEAN_W]);
          check_field("variance_fixed", want.variance_fixed, out_tdata[VAR_LO +: VAR_W]);
        end
        stall = $urandom_range(0, out_gap_max);
      end
      if (stall > 0) begin
        out_tready <= 1'b0;
        stall--;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // one pixel item, valid left high so a following item can go back to back
  task automatic send_pixel(bit [PIX_W-1:0] r, bit [PIX_W-1:0] g, bit [PIX_W-1:0] b);
    int gap;
    gap = $urandom_range(0, in_gap_max);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {b, g, r};
    do @(posedge clk); while (!in_tready);
    predict_pixel(r, g, b);
  endtask

  // stop the pixel stream until every predicted row has come out
  task automatic hold_until_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (rows_due.size() != 0);
  endtask

  // drained plus the final-row latency, so the block is idle
  task automatic settle();
    hold_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, bit [CFG_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_COLUMNS) begin
      geo_columns = value;
    end else begin
      geo_rows = value;
    end
    @(posedge clk);
  endtask

  task automatic configure(bit [CFG_W-1:0] cols, bit [CFG_W-1:0] nrows);
    settle();
    write_reg(REG_COLUMNS, cols);
    write_reg(REG_ROWS, nrows);
  endtask

  function automatic bit [IN_TDATA_W-1:0] pick_pixel(int black_pct);
    bit [IN_TDATA_W-1:0] px;
    if ($urandom_range(0, 99) < black_pct) begin
      px = '0;
    end else begin
      case ($urandom_range(0, 3))
        0: px = IN_TDATA_W'($urandom());
        1: px = {16'h0, 8'($urandom_range(1, 255))};
        2: px = {8'h0, 8'($urandom_range(1, 255)), 8'h0};
        default: px = {8'($urandom_range(1, 255)), 16'h0};
      endcase
    end
    return px;
  endfunction

  // run of random pixels, now and then held until the results catch up
  task automatic send_run(int n, int black_pct);
    bit [IN_TDATA_W-1:0] px;
    for (int i = 0; i < n; i++) begin
      px = pick_pixel(black_pct);
      send_pixel(px[7:0], px[15:8], px[23:16]);
      if ($urandom_range(0, 199) == 0) begin
        hold_until_drained();
      end
    end
  endtask

  // row length out of reset, then a frame closed early by a mid-frame write
  task automatic test_reset_geometry();
    send_run(640, 50);
    settle();
    write_reg(REG_COLUMNS, CFG_W'(3));
    write_reg(REG_ROWS, CFG_W'(2));
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd7, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd0, 8'd0);
  endtask

  // channel extremes and single-channel pixels
  task automatic test_pixel_extremes();
    configure(CFG_W'(4), CFG_W'(3));
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd255, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd0, 8'd255);
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd1, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd0, 8'd128);
    repeat (4) send_pixel(8'd0, 8'd0, 8'd0);
  endtask

  // shrinking columns mid-row and rows mid-frame
  task automatic test_mid_frame_change();
    configure(CFG_W'(6), CFG_W'(4));
    repeat (4) send_pixel(8'd0, 8'd0, 8'd0);
    settle();
    write_reg(REG_COLUMNS, CFG_W'(2));
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd1, 8'd0);
    send_pixel(8'd0, 8'd0, 8'd0);
    settle();
    write_reg(REG_ROWS, CFG_W'(1));
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd0, 8'd0);
  endtask

  // zero registers act as one: every pixel closes a frame
  task automatic test_zero_registers();
    configure(CFG_W'(0), CFG_W'(0));
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd0, 8'd1);
  endtask

  // oversized registers clamp, so no row or frame ends early; a later shrink closes them
  task automatic test_size_limits();
    configure(CFG_W'(8191), CFG_W'(0));
    send_run(60, 100);
    settle();
    write_reg(REG_COLUMNS, CFG_W'(61));
    send_pixel(8'd0, 8'd0, 8'd0);
    configure(CFG_W'(1), CFG_W'(8191));
    for (int i = 0; i < 50; i++) begin
      if (i % 2 == 0) begin
        send_pixel(8'd0, 8'd0, 8'd0);
      end else begin
        send_pixel(8'd0, 8'd0, 8'd64);
      end
    end
    settle();
    write_reg(REG_ROWS, CFG_W'(40));
    send_pixel(8'd0, 8'd0, 8'd0);
  endtask

  // random geometries, mostly whole frames, some cut short before the next write
  task automatic test_random(int budget);
    int sent;
    int cols;
    int nrows;
    int pixels;
    int n;
    int black_pct;
    sent = 0;
    while (sent < budget) begin
      case ($urandom_range(0, 9))
        0: cols = 0;
        1: cols = $urandom_range(9, 40);
        default: cols = $urandom_range(1, 8);
      endcase
      case ($urandom_range(0, 9))
        0: nrows = 0;
        1: nrows = $urandom_range(7, 12);
        default: nrows = $urandom_range(1, 6);
      endcase
      configure(CFG_W'(cols), CFG_W'(nrows));
      in_gap_max  = ($urandom_range(0, 4) == 0) ? 0 : GAP_MAX;
      out_gap_max = ($urandom_range(0, 4) == 0) ? 0 : GAP_MAX;
      case ($urandom_range(0, 4))
        0: black_pct = 0;
        1: black_pct = 25;
        2: black_pct = 50;
        3: black_pct = 90;
        default: black_pct = 100;
      endcase
      pixels = ((cols == 0) ? 1 : cols) * ((nrows == 0) ? 1 : nrows);
      n = pixels * ((pixels > 120) ? 1 : $urandom_range(1, 3));
      // broken frame: the next write lands mid-row or mid-frame
      if ($urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, n);
      end
      send_run(n, black_pct);
      sent += n;
    end
    in_gap_max  = GAP_MAX;
    out_gap_max = GAP_MAX;
  endtask

  // reset, predictor reset, tests in turn, verdict
  initial begin
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    cfg_valid    = 1'b0;
    cfg_index    = REG_COLUMNS;
    cfg_data     = '0;
    geo_columns  = COLUMNS_RST;
    geo_rows     = ROWS_RST;
    col_pos      = '0;
    row_pos      = '0;
    row_black    = '0;
    black_sum    = '0;
    black_sq_sum = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_geometry();
    test_pixel_extremes();
    test_mid_frame_change();
    test_zero_registers();
    test_size_limits();
    test_random(370);

    settle();
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/rpv_pkg.sv
rtl/rpv_front.sv
rtl/rpv_queue.sv
rtl/rpv_div.sv
rtl/rpv_back.sv
rtl/row_projection_variance_unit.sv
rtl/rpv_checker.sv
verif/testbench.sv
